// ----- src/cfcr_pkg.sv -----
// Shared types, constants and pattern lookups for the checked frame receiver.
// Used by the frame RAM, the CRC unit and the receiver core.
package cfcr_pkg;

	localparam int FRAME_LEN = 23;
	localparam int ADDR_W    = 5;

	localparam logic [ADDR_W-1:0] HDR_LEN_A   = 5'd4;
	localparam logic [ADDR_W-1:0] PAY_FIRST_A = 5'd4;
	localparam logic [ADDR_W-1:0] PAY_LAST_A  = 5'd19;
	localparam logic [ADDR_W-1:0] TAIL_POS_A  = 5'd20;
	localparam logic [ADDR_W-1:0] CRC_HI_A    = 5'd21;
	localparam logic [ADDR_W-1:0] CRC_LO_A    = 5'd22;

	localparam logic [7:0] HDR_C     = 8'h63;
	localparam logic [7:0] HDR_2     = 8'h32;
	localparam logic [7:0] HDR_M     = 8'h6d;
	localparam logic [7:0] HDR_BRACE = 8'h7b;
	localparam logic [7:0] TAIL_CHAR = 8'h7d;
	localparam logic [7:0] CHR_DASH  = 8'h2d;
	localparam logic [7:0] CHR_S     = 8'h73;
	localparam logic [7:0] CHR_Y     = 8'h79;
	localparam logic [7:0] CHR_N     = 8'h6e;
	localparam logic [7:0] CHR_A     = 8'h61;
	localparam logic [7:0] CHR_K     = 8'h6b;

	localparam logic [15:0] POLY_RESET = 16'h1021;
	localparam logic [15:0] INIT_RESET = 16'hffff;

	localparam logic REG_POLY = 1'b0;
	localparam logic REG_INIT = 1'b1;

	localparam logic [2:0] OUT_CRC_BAD    = 3'd0;
	localparam logic [2:0] OUT_SYNC       = 3'd1;
	localparam logic [2:0] OUT_ACK        = 3'd2;
	localparam logic [2:0] OUT_PAYLOAD    = 3'd3;
	localparam logic [2:0] OUT_UNEXPECTED = 3'd4;

	localparam logic [1:0] PH_WAIT_SYNC = 2'd0;
	localparam logic [1:0] PH_WAIT_ACK  = 2'd1;
	localparam logic [1:0] PH_LINKED    = 2'd2;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	typedef struct packed {
		logic load;
		logic step;
	} crc_ctl_t;

	function automatic logic [7:0] hdr_char(input logic [1:0] k);
		logic [7:0] c;
		unique case (k)
			2'd0: c = HDR_C;
			2'd1: c = HDR_2;
			2'd2: c = HDR_M;
			default: c = HDR_BRACE;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] sync_char(input logic [3:0] k);
		logic [7:0] c;
		unique case (k)
			4'd6: c = CHR_S;
			4'd7: c = CHR_Y;
			4'd8: c = CHR_N;
			4'd9: c = HDR_C;
			default: c = CHR_DASH;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] sack_char(input logic [3:0] k);
		logic [7:0] c;
		unique case (k)
			4'd6: c = CHR_S;
			4'd7: c = CHR_A;
			4'd8: c = HDR_C;
			4'd9: c = CHR_K;
			default: c = CHR_DASH;
		endcase
		return c;
	endfunction

endpackage

// ----- src/cfcr_frame_ram.sv -----
// Frame byte store: one write port, one registered read port.
// Depends on cfcr_pkg for the write bundle and address width.
module cfcr_frame_ram (
	input  logic                            clk,
	input  cfcr_pkg::ram_wr_t               wr,
	input  logic                            rd_en,
	input  logic [cfcr_pkg::ADDR_W-1:0]     rd_addr,
	output logic [7:0]                      rd_data
);

	logic [7:0] mem [cfcr_pkg::FRAME_LEN];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/cfcr_crc_unit.sv -----
// Byte-wide MSB-first CRC-16 register with programmable polynomial and seed.
// Depends on cfcr_pkg for the control bundle.
module cfcr_crc_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  cfcr_pkg::crc_ctl_t ctl,
	input  logic [7:0]         data_in,
	input  logic [15:0]        poly,
	input  logic [15:0]        init,
	output logic [15:0]        crc
);

	logic [15:0] crc_q;
	logic [15:0] crc_next;

	always_comb begin
		crc_next = crc_q ^ {data_in, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (crc_next[15]) begin
				crc_next = {crc_next[14:0], 1'b0} ^ poly;
			end else begin
				crc_next = {crc_next[14:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 16'h0000;
		end else if (ctl.load) begin
			crc_q <= init;
		end else if (ctl.step) begin
			crc_q <= crc_next;
		end
	end

	assign crc = crc_q;

endmodule

// ----- src/crc_checked_frame_receiver_core.sv -----
// Receiver core: byte sequencer, header realignment, CRC check and link handshake.
// Depends on cfcr_pkg, cfcr_frame_ram and cfcr_crc_unit.
//
// channel | dir | handshake         | content
// s_*     | in  | s_tvalid/s_tready | s_tdata: rx_byte
// m_*     | out | m_tvalid/m_tready | m_tdata: outcome, phase, payload
// cfg_*   | in  | cfg_we            | cfg_index, cfg_data
//
// A byte that does not end or break a frame leaves the core idle, so s_tready stays high.
// A missing tail starts a header search and, if a header start is found, byte moves,
// both bound by the single read port of the frame RAM.
// The last byte of a frame streams the payload through the CRC unit behind the RAM read,
// then loads the output register once it is free.
// Reset clears the byte count, link phase, state and output valid; the frame RAM is not cleared.
// s_tready is low during search, move and check, and while a result waits for the output register.
module crc_checked_frame_receiver_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] rx_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // [2:0] frame_outcome, [4:3] handshake_state,
	                                // [68:5] payload_high, [132:69] payload_low, zero fill
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_MOVE = 3'd2;
	localparam logic [2:0] ST_CRC  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]   state_q;
	logic [4:0]   count_q;
	logic [1:0]   phase_q;
	logic [15:0]  poly_q;
	logic [15:0]  init_q;
	logic [7:0]   crc_hi_q;
	logic [7:0]   crc_lo_q;
	logic [4:0]   ptr_q;
	logic [4:0]   lim_q;
	logic [4:0]   dst_q;
	logic [2:0]   match_q;
	logic         sync_ok_q;
	logic         sack_ok_q;
	logic [127:0] pay_q;
	logic         pend_s1;
	logic [4:0]   idx_s1;

	logic         out_vld_q;
	logic [2:0]   out_outcome_q;
	logic [1:0]   out_phase_q;
	logic [127:0] out_pay_q;

	logic                  accept;
	logic                  issue;
	logic [7:0]            rd_data;
	cfcr_pkg::ram_wr_t     ram_wr;
	cfcr_pkg::crc_ctl_t    crc_ctl;
	logic [15:0]           crc_val;
	logic                  hdr_bad;
	logic                  tail_bad;
	logic [2:0]            match_nxt;
	logic [3:0]            pay_k;
	logic                  out_free;
	logic                  load_out;
	logic                  scan_stop;
	logic [2:0]            res_outcome;
	logic [1:0]            res_phase;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign issue    = ((state_q == ST_SCAN) || (state_q == ST_MOVE) || (state_q == ST_CRC))
	                  && (ptr_q <= lim_q);
	assign out_free = !out_vld_q || m_tready;
	assign load_out = (state_q == ST_OUT) && out_free;
	assign scan_stop = (state_q == ST_SCAN) && pend_s1
	                   && ((match_nxt == 3'd4) || (idx_s1 == cfcr_pkg::TAIL_POS_A));

	assign hdr_bad  = (count_q < cfcr_pkg::HDR_LEN_A)
	                  && (s_tdata != cfcr_pkg::hdr_char(count_q[1:0]));
	assign tail_bad = (count_q == cfcr_pkg::TAIL_POS_A) && (s_tdata != cfcr_pkg::TAIL_CHAR);

	always_comb begin
		if (rd_data == cfcr_pkg::hdr_char(match_q[1:0])) begin
			match_nxt = match_q + 3'd1;
		end else if (rd_data == cfcr_pkg::HDR_C) begin
			match_nxt = 3'd1;
		end else begin
			match_nxt = 3'd0;
		end
	end

	assign pay_k = 4'(idx_s1 - cfcr_pkg::PAY_FIRST_A);

	always_comb begin
		ram_wr.we   = 1'b0;
		ram_wr.addr = count_q;
		ram_wr.data = s_tdata;
		if (accept) begin
			ram_wr.we = 1'b1;
		end else if ((state_q == ST_MOVE) && pend_s1) begin
			ram_wr.we   = 1'b1;
			ram_wr.addr = dst_q;
			ram_wr.data = rd_data;
		end
	end

	always_comb begin
		crc_ctl.load = accept && (count_q == cfcr_pkg::CRC_LO_A);
		crc_ctl.step = (state_q == ST_CRC) && pend_s1;
	end

	always_comb begin
		res_phase = phase_q;
		if (crc_val != {crc_hi_q, crc_lo_q}) begin
			res_outcome = cfcr_pkg::OUT_CRC_BAD;
		end else begin
			unique case (phase_q)
				cfcr_pkg::PH_WAIT_SYNC: begin
					if (sync_ok_q) begin
						res_outcome = cfcr_pkg::OUT_SYNC;
						res_phase   = cfcr_pkg::PH_WAIT_ACK;
					end else begin
						res_outcome = cfcr_pkg::OUT_UNEXPECTED;
					end
				end
				cfcr_pkg::PH_WAIT_ACK: begin
					if (sack_ok_q) begin
						res_outcome = cfcr_pkg::OUT_ACK;
						res_phase   = cfcr_pkg::PH_LINKED;
					end else begin
						res_outcome = cfcr_pkg::OUT_UNEXPECTED;
					end
				end
				cfcr_pkg::PH_LINKED: res_outcome = cfcr_pkg::OUT_PAYLOAD;
				default:             res_outcome = cfcr_pkg::OUT_UNEXPECTED;
			endcase
		end
	end

	cfcr_frame_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (issue),
		.rd_addr (ptr_q),
		.rd_data (rd_data)
	);

	cfcr_crc_unit u_crc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (crc_ctl),
		.data_in (rd_data),
		.poly    (poly_q),
		.init    (init_q),
		.crc     (crc_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= cfcr_pkg::POLY_RESET;
			init_q <= cfcr_pkg::INIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cfcr_pkg::REG_POLY: poly_q <= cfg_data;
				cfcr_pkg::REG_INIT: init_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= 5'd0;
			phase_q   <= cfcr_pkg::PH_WAIT_SYNC;
			ptr_q     <= 5'd0;
			lim_q     <= 5'd0;
			pend_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			pend_s1 <= issue && !scan_stop;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (hdr_bad) begin
							count_q <= 5'd0;
						end else if (tail_bad) begin
							state_q <= ST_SCAN;
							ptr_q   <= cfcr_pkg::PAY_FIRST_A;
							lim_q   <= cfcr_pkg::TAIL_POS_A;
						end else if (count_q == cfcr_pkg::CRC_LO_A) begin
							state_q <= ST_CRC;
							ptr_q   <= cfcr_pkg::PAY_FIRST_A;
							lim_q   <= cfcr_pkg::PAY_LAST_A;
						end else begin
							count_q <= count_q + 5'd1;
						end
					end
				end
				ST_SCAN: begin
					if (pend_s1 && (match_nxt == 3'd4)) begin
						state_q <= ST_MOVE;
						ptr_q   <= idx_s1 - 5'd3;
					end else if (pend_s1 && (idx_s1 == cfcr_pkg::TAIL_POS_A)) begin
						if (match_nxt != 3'd0) begin
							state_q <= ST_MOVE;
							ptr_q   <= cfcr_pkg::CRC_HI_A - {2'b00, match_nxt};
						end else begin
							state_q <= ST_IDLE;
							count_q <= 5'd0;
						end
					end else if (issue) begin
						ptr_q <= ptr_q + 5'd1;
					end
				end
				ST_MOVE: begin
					if (issue) begin
						ptr_q <= ptr_q + 5'd1;
					end
					if (pend_s1 && (idx_s1 == cfcr_pkg::TAIL_POS_A)) begin
						state_q <= ST_IDLE;
						count_q <= dst_q + 5'd1;
					end
				end
				ST_CRC: begin
					if (issue) begin
						ptr_q <= ptr_q + 5'd1;
					end
					if (pend_s1 && (idx_s1 == cfcr_pkg::PAY_LAST_A)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						phase_q <= res_phase;
						count_q <= 5'd0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q;
		if (accept) begin
			if (count_q == cfcr_pkg::CRC_HI_A) begin
				crc_hi_q <= s_tdata;
			end
			if (count_q == cfcr_pkg::CRC_LO_A) begin
				crc_lo_q <= s_tdata;
			end
			match_q   <= 3'd0;
			dst_q     <= 5'd0;
			sync_ok_q <= 1'b1;
			sack_ok_q <= 1'b1;
		end
		if ((state_q == ST_SCAN) && pend_s1) begin
			match_q <= match_nxt;
		end
		if ((state_q == ST_MOVE) && pend_s1) begin
			dst_q <= dst_q + 5'd1;
		end
		if ((state_q == ST_CRC) && pend_s1) begin
			pay_q     <= {pay_q[119:0], rd_data};
			sync_ok_q <= sync_ok_q && (rd_data == cfcr_pkg::sync_char(pay_k));
			sack_ok_q <= sack_ok_q && (rd_data == cfcr_pkg::sack_char(pay_k));
		end
		if (load_out) begin
			out_outcome_q <= res_outcome;
			out_phase_q   <= res_phase;
			out_pay_q     <= pay_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, out_pay_q[63:0], out_pay_q[127:64], out_phase_q, out_outcome_q};

endmodule

// ----- tb/cfcr_frame_checker.sv -----
`timescale 1ns / 1ps
// Checker for the checked frame receiver: tracks byte, result and register transactions,
// predicts each frame result and compares it field by field. Depends on cfcr_pkg.
module cfcr_frame_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [135:0] m_tdata,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data,
	output int           fail_count,
	output int           pending
);

	localparam int TAIL_IDX = 20;
	localparam logic [31:0]  HEADER_SEQ = {cfcr_pkg::HDR_C, cfcr_pkg::HDR_2, cfcr_pkg::HDR_M,
		cfcr_pkg::HDR_BRACE};
	localparam logic [127:0] SYNC_BYTES = {{6{cfcr_pkg::CHR_DASH}}, cfcr_pkg::CHR_S,
		cfcr_pkg::CHR_Y, cfcr_pkg::CHR_N, cfcr_pkg::HDR_C, {6{cfcr_pkg::CHR_DASH}}};
	localparam logic [127:0] SACK_BYTES = {{6{cfcr_pkg::CHR_DASH}}, cfcr_pkg::CHR_S,
		cfcr_pkg::CHR_A, cfcr_pkg::HDR_C, cfcr_pkg::CHR_K, {6{cfcr_pkg::CHR_DASH}}};

	typedef struct packed {
		logic [2:0]  outcome;
		logic [1:0]  phase;
		logic [63:0] pay_hi;
		logic [63:0] pay_lo;
	} frame_result_t;

	logic [7:0]    rx_frame [cfcr_pkg::FRAME_LEN];
	int            rx_count;
	logic [1:0]    link_state;
	logic [15:0]   crc_poly;
	logic [15:0]   crc_seed;
	frame_result_t expected_frames [$];

	function automatic logic [7:0] header_byte(input int k);
		return HEADER_SEQ[31 - 8 * k -: 8];
	endfunction

	function automatic logic [15:0] stored_payload_crc();
		logic [15:0] crc;
		crc = crc_seed;
		for (int i = 4; i < 20; i++) begin
			crc ^= {rx_frame[i], 8'h00};
			for (int b = 0; b < 8; b++)
				crc = crc[15] ? ({crc[14:0], 1'b0} ^ crc_poly) : {crc[14:0], 1'b0};
		end
		return crc;
	endfunction

	function automatic bit header_starts(input int i);
		for (int k = 0; k < 4; k++) begin
			if (i + k > TAIL_IDX)
				return 1'b1;
			if (rx_frame[i + k] != header_byte(k))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic absorb_byte(input logic [7:0] b);
		int            found;
		int            n;
		logic [127:0]  pay;
		logic [15:0]   got;
		frame_result_t r;
		if (rx_count >= cfcr_pkg::FRAME_LEN)
			rx_count = 0;
		rx_frame[rx_count] = b;
		rx_count++;
		if (rx_count <= 4 && rx_frame[rx_count - 1] != header_byte(rx_count - 1))
			rx_count = 0;
		if (rx_count == 21 && rx_frame[TAIL_IDX] != cfcr_pkg::TAIL_CHAR) begin
			found = 0;
			for (int i = 4; i <= TAIL_IDX; i++)
				if (found == 0 && header_starts(i))
					found = i;
			if (found != 0) begin
				n = 21 - found;
				for (int k = 0; k < n; k++)
					rx_frame[k] = rx_frame[k + found];
				rx_count = n;
			end else begin
				rx_count = 0;
			end
		end
		if (rx_count != cfcr_pkg::FRAME_LEN)
			return;
		pay = '0;
		for (int k = 4; k < 20; k++)
			pay = {pay[119:0], rx_frame[k]};
		got = {rx_frame[21], rx_frame[22]};
		if (stored_payload_crc() != got) begin
			r.outcome = cfcr_pkg::OUT_CRC_BAD;
		end else begin
			case (link_state)
				cfcr_pkg::PH_WAIT_SYNC: begin
					if (pay == SYNC_BYTES) begin
						link_state = cfcr_pkg::PH_WAIT_ACK;
						r.outcome = cfcr_pkg::OUT_SYNC;
					end else begin
						r.outcome = cfcr_pkg::OUT_UNEXPECTED;
					end
				end
				cfcr_pkg::PH_WAIT_ACK: begin
					if (pay == SACK_BYTES) begin
						link_state = cfcr_pkg::PH_LINKED;
						r.outcome = cfcr_pkg::OUT_ACK;
					end else begin
						r.outcome = cfcr_pkg::OUT_UNEXPECTED;
					end
				end
				cfcr_pkg::PH_LINKED: r.outcome = cfcr_pkg::OUT_PAYLOAD;
				default: r.outcome = cfcr_pkg::OUT_UNEXPECTED;
			endcase
		end
		r.phase  = link_state;
		r.pay_hi = pay[127:64];
		r.pay_lo = pay[63:0];
		expected_frames.push_back(r);
		rx_count = 0;
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		frame_result_t e;
		if (!arst_n) begin
			rx_count   = 0;
			link_state = cfcr_pkg::PH_WAIT_SYNC;
			crc_poly   = cfcr_pkg::POLY_RESET;
			crc_seed   = cfcr_pkg::INIT_RESET;
			fail_count = 0;
			expected_frames.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_frames.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none actual %0h", $time, m_tdata);
				end else begin
					e = expected_frames.pop_front();
					check_field("frame_outcome", 64'(e.outcome), 64'(m_tdata[2:0]));
					check_field("handshake_state", 64'(e.phase), 64'(m_tdata[4:3]));
					check_field("payload_high", e.pay_hi, m_tdata[68:5]);
					check_field("payload_low", e.pay_lo, m_tdata[132:69]);
				end
			end
			if (s_tvalid && s_tready)
				absorb_byte(s_tdata);
			if (cfg_we) begin
				if (cfg_index == cfcr_pkg::REG_POLY)
					crc_poly = cfg_data;
				else
					crc_seed = cfg_data;
			end
		end
		pending = expected_frames.size();
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the frame receiver testbench: clock, reset, byte and register stimulus, result
// back-pressure and the verdict. Depends on cfcr_pkg, the receiver core and cfcr_frame_checker.
module tb_top;

	localparam int HOLD_SEG     = 4;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 64;
	localparam int SEG_BYTES    = 120;
	localparam logic [127:0] SYNC_BYTES = {{6{cfcr_pkg::CHR_DASH}}, cfcr_pkg::CHR_S,
		cfcr_pkg::CHR_Y, cfcr_pkg::CHR_N, cfcr_pkg::HDR_C, {6{cfcr_pkg::CHR_DASH}}};
	localparam logic [127:0] SACK_BYTES = {{6{cfcr_pkg::CHR_DASH}}, cfcr_pkg::CHR_S,
		cfcr_pkg::CHR_A, cfcr_pkg::HDR_C, cfcr_pkg::CHR_K, {6{cfcr_pkg::CHR_DASH}}};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;
	logic         cfg_we = 1'b0;
	logic         cfg_index = cfcr_pkg::REG_POLY;
	logic [15:0]  cfg_data = 16'h0000;
	int           fail_count;
	int           pending;

	int unsigned  tx_idle = 37;
	int unsigned  rx_idle = 51;
	int           segment = 0;
	bit           hold_done = 1'b0;
	int           sent_count = 0;
	logic [15:0]  cur_poly = cfcr_pkg::POLY_RESET;
	logic [15:0]  cur_seed = cfcr_pkg::INIT_RESET;

	crc_checked_frame_receiver_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	cfcr_frame_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (segment == HOLD_SEG && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	function automatic logic [15:0] link_crc(input logic [127:0] pay);
		logic [15:0] crc;
		crc = cur_seed;
		for (int i = 15; i >= 0; i--) begin
			crc ^= {pay[8 * i +: 8], 8'h00};
			for (int b = 0; b < 8; b++)
				crc = crc[15] ? ({crc[14:0], 1'b0} ^ cur_poly) : {crc[14:0], 1'b0};
		end
		return crc;
	endfunction

	function automatic logic [183:0] frame_bits(input logic [127:0] pay,
		input logic [15:0] crc_flip);
		return {cfcr_pkg::HDR_C, cfcr_pkg::HDR_2, cfcr_pkg::HDR_M, cfcr_pkg::HDR_BRACE, pay,
			cfcr_pkg::TAIL_CHAR, link_crc(pay) ^ crc_flip};
	endfunction

	function automatic logic [127:0] random_payload();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_count++;
	endtask

	task automatic send_stream(input logic [183:0] bits, input int n);
		for (int k = 0; k < n; k++)
			send_byte(bits[183 - 8 * k -: 8]);
	endtask

	task automatic send_frame(input logic [127:0] pay, input logic [15:0] crc_flip);
		send_stream(frame_bits(pay, crc_flip), cfcr_pkg::FRAME_LEN);
	endtask

	// header, filler free of header starts, then a whole frame that the tail search lands on
	task automatic send_realigned(input int j, input logic [127:0] pay);
		logic [7:0] b;
		send_stream(frame_bits(pay, 16'h0000), 4);
		for (int k = 4; k < j; k++) begin
			b = 8'($urandom_range(255));
			send_byte(b == cfcr_pkg::HDR_C ? cfcr_pkg::CHR_DASH : b);
		end
		send_frame(pay, 16'h0000);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_crc(input logic [15:0] poly, input logic [15:0] seed);
		cfg_we    <= 1'b1;
		cfg_index <= cfcr_pkg::REG_POLY;
		cfg_data  <= poly;
		@(posedge clk);
		cfg_index <= cfcr_pkg::REG_INIT;
		cfg_data  <= seed;
		@(posedge clk);
		cfg_we   <= 1'b0;
		cur_poly = poly;
		cur_seed = seed;
	endtask

	task automatic send_random_item();
		int          r;
		int          n;
		logic [15:0] flip;
		r = $urandom_range(99);
		if (r < 35) begin
			send_frame(random_payload(), 16'h0000);
		end else if (r < 45) begin
			send_frame(SYNC_BYTES, 16'h0000);
		end else if (r < 55) begin
			send_frame(SACK_BYTES, 16'h0000);
		end else if (r < 70) begin
			flip = 16'($urandom_range(16'hffff, 1));
			send_frame(random_payload(), flip);
		end else if (r < 82) begin
			send_realigned($urandom_range(20, 4), random_payload());
		end else if (r < 92) begin
			n = $urandom_range(6, 1);
			repeat (n) send_byte(8'($urandom_range(255)));
		end else begin
			n = $urandom_range(3, 1);
			send_stream(frame_bits(128'h0, 16'h0000), n);
			send_byte(8'($urandom_range(255)));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// broken headers at each position
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(cfcr_pkg::HDR_C);
		send_byte(8'hff);
		send_byte(cfcr_pkg::HDR_C);
		send_byte(cfcr_pkg::HDR_2);
		send_byte(8'h00);
		send_stream(frame_bits(128'h0, 16'h0000), 3);
		send_byte(8'h80);
		// phase-0 frames: good but unexpected, bad check, ack too early
		send_frame(128'h0, 16'h0000);
		send_frame({16{8'hff}}, 16'h0001);
		send_frame(SACK_BYTES, 16'h0000);
		// missing tail with no header to realign on
		send_stream(frame_bits(128'h0, 16'h0000), 4);
		repeat (17) send_byte(8'h00);
		// realign onto a cut-off header and onto one right after the first
		send_realigned(20, {16{8'hff}});
		send_realigned(4, random_payload());
		// handshake
		send_frame(SYNC_BYTES, 16'h0000);
		send_frame(SYNC_BYTES, 16'h0000);
		send_frame(SACK_BYTES, 16'h8000);
		send_frame(SACK_BYTES, 16'h0000);
		send_frame(random_payload(), 16'h0000);
		drain();

		for (int seg = 0; seg < 6; seg++) begin
			case (seg)
				1: set_crc(16'h0000, 16'h0000);
				2: set_crc(16'hffff, 16'hffff);
				3: set_crc(16'($urandom_range(16'hffff)), 16'($urandom_range(16'hffff)));
				4: set_crc(16'h8005, 16'h0000);
				5: set_crc(cfcr_pkg::POLY_RESET, cfcr_pkg::INIT_RESET);
				default: ;
			endcase
			if (seg < 2) begin
				tx_idle = 37;
				rx_idle = 51;
			end else if (seg < 4) begin
				tx_idle = 51;
				rx_idle = 37;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			segment = seg;
			n_loop: begin
				int stop_at;
				stop_at = sent_count + SEG_BYTES;
				while (sent_count < stop_at)
					send_random_item();
			end
			drain();
		end

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
